// File: hdl/yrr_pkg.sv
// ----------------------------------------------------------------------------
// yrr_pkg: shared types and constants of the YUV 4:2:0 round-trip block
// Holds the request structs, the lane control struct and the BT.601
// coefficient table in micro units, with its fixed-point rounding function.
// ----------------------------------------------------------------------------
package yrr_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int RGB_FRAC_BITS      = 8;
    localparam int LANES              = 4;
    localparam int LANE_STAGES        = 4;

    // Coefficients in millionths.
    localparam longint MICRO_Y_GAIN = 1164383;
    localparam longint MICRO_V_R    = 1596027;
    localparam longint MICRO_U_B    = 2017232;
    localparam longint MICRO_U_G    = 391762;
    localparam longint MICRO_V_G    = 812968;
    localparam longint MICRO_R_Y    = 256788;
    localparam longint MICRO_G_Y    = 504129;
    localparam longint MICRO_B_Y    = 97906;
    localparam longint MICRO_B_U    = 439216;
    localparam longint MICRO_G_U    = 290993;
    localparam longint MICRO_R_U    = 148223;
    localparam longint MICRO_R_V    = 439216;
    localparam longint MICRO_G_V    = 367788;
    localparam longint MICRO_B_V    = 71427;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue_in;
        logic [7:0] chroma_red_in;
    } yrr_blk_t;

    typedef struct packed {
        logic [7:0] new_luma_top_left;
        logic [7:0] new_luma_top_right;
        logic [7:0] new_luma_bottom_left;
        logic [7:0] new_luma_bottom_right;
        logic [7:0] chroma_blue_out;
        logic [7:0] chroma_red_out;
    } yrr_res_t;

    // Load enables of the lane pipeline stages, first stage in bit 0.
    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
    } yrr_ctl_t;

    // Round-trip YUV of one pixel.
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } yrr_pix_t;

    // Rounds a coefficient to nearest, halves up, with frac fractional bits.
    function automatic longint coef(longint micro, int frac);
        return ((micro << frac) + 64'sd500000) / 64'sd1000000;
    endfunction

endpackage

// File: hdl/yuv420_rgb_roundtrip_top.sv
// ----------------------------------------------------------------------------
// yuv420_rgb_roundtrip_top: BT.601 YUV 4:2:0 to RGB and back, one block a cycle
// A request passes the four lane stages and then the output register to res_data.
// Throughput is one 2x2 block per cycle while the sink does not stall, set by four lanes
// that each hold a 4-stage multiply pipeline, followed by one output register.
// Reset clears only the stage valid flags; no request is in flight after it.
// ----------------------------------------------------------------------------
module yuv420_rgb_roundtrip_top #(
    parameter int COEF_FRAC_BITS = yrr_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              blk_valid,
    output logic              blk_stall,
    input  yrr_pkg::yrr_blk_t blk_data,
    output logic              res_valid,
    input  logic              res_stall,
    output yrr_pkg::yrr_res_t res_data
);
    import yrr_pkg::*;

    // Stage LANE_STAGES is the output register of the merge stage; stages
    // below it are the lane pipeline stages, shared by all four lanes.
    localparam int NSTAGE = LANE_STAGES + 1;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] en;
    yrr_ctl_t          lane_ctl;

    // A stage loads when it is empty or when its content moves on. Bubbles
    // collapse, so new requests are taken while a result waits at the output
    // as long as some stage is empty.
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || !res_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? blk_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign lane_ctl.en = en[LANE_STAGES-1:0];
    assign blk_stall   = !en[0];
    assign res_valid   = valid_reg[NSTAGE-1];

    // Pixel order of the lanes: top-left, top-right, bottom-left,
    // bottom-right. The merge stage relies on lane 0 being top-left.
    logic [7:0] luma_in [LANES];
    yrr_pix_t   lane_pix [LANES];

    assign luma_in[0] = blk_data.luma_top_left;
    assign luma_in[1] = blk_data.luma_top_right;
    assign luma_in[2] = blk_data.luma_bottom_left;
    assign luma_in[3] = blk_data.luma_bottom_right;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        yrr_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk         (clk),
            .ctl         (lane_ctl),
            .luma        (luma_in[i]),
            .chroma_blue (blk_data.chroma_blue_in),
            .chroma_red  (blk_data.chroma_red_in),
            .pix         (lane_pix[i])
        );
    end

    // The merge stage is the output register; it loads with the last enable.
    yrr_merge u_merge (
        .clk (clk),
        .en  (en[NSTAGE-1]),
        .pix (lane_pix),
        .res (res_data)
    );

endmodule

// File: hdl/yrr_lane.sv
// ----------------------------------------------------------------------------
// yrr_lane: one pixel lane of the YUV to RGB to YUV round trip
// Four stages: forward products, RGB sum and clamp, back products, and the
// back sums with the conversion to bytes.
// ----------------------------------------------------------------------------
module yrr_lane #(
    parameter int COEF_FRAC_BITS = yrr_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  yrr_pkg::yrr_ctl_t  ctl,
    input  logic [7:0]         luma,
    input  logic [7:0]         chroma_blue,
    input  logic [7:0]         chroma_red,
    output yrr_pkg::yrr_pix_t  pix
);
    import yrr_pkg::*;

    localparam int F      = COEF_FRAC_BITS;
    localparam int KW     = F + 3;
    localparam int PW     = F + 13;
    localparam int SW     = F + 11;
    localparam int DROP   = F - RGB_FRAC_BITS;
    localparam int QW     = SW - DROP;
    localparam int MW     = F + 16;
    localparam int BW     = F + 18;
    localparam int BSHIFT = F + RGB_FRAC_BITS;
    localparam int TW     = BW - BSHIFT;

    localparam logic signed [KW-1:0] K_Y  = KW'(coef(MICRO_Y_GAIN, F));
    localparam logic signed [KW-1:0] K_VR = KW'(coef(MICRO_V_R, F));
    localparam logic signed [KW-1:0] K_UB = KW'(coef(MICRO_U_B, F));
    localparam logic signed [KW-1:0] K_UG = KW'(coef(MICRO_U_G, F));
    localparam logic signed [KW-1:0] K_VG = KW'(coef(MICRO_V_G, F));

    localparam logic [F-1:0] K_RY = F'(coef(MICRO_R_Y, F));
    localparam logic [F-1:0] K_GY = F'(coef(MICRO_G_Y, F));
    localparam logic [F-1:0] K_BY = F'(coef(MICRO_B_Y, F));
    localparam logic [F-1:0] K_RU = F'(coef(MICRO_R_U, F));
    localparam logic [F-1:0] K_GU = F'(coef(MICRO_G_U, F));
    localparam logic [F-1:0] K_BU = F'(coef(MICRO_B_U, F));
    localparam logic [F-1:0] K_RV = F'(coef(MICRO_R_V, F));
    localparam logic [F-1:0] K_GV = F'(coef(MICRO_G_V, F));
    localparam logic [F-1:0] K_BV = F'(coef(MICRO_B_V, F));

    localparam logic [15:0] RGB_MAX = 16'(255 << RGB_FRAC_BITS);
    localparam logic signed [BW-1:0] OFF_Y  = BW'(longint'(16) << BSHIFT);
    localparam logic signed [BW-1:0] OFF_UV = BW'(longint'(128) << BSHIFT);

    function automatic logic [15:0] clamp_rgb(logic signed [SW-1:0] acc);
        logic [QW-1:0] q;
        q = acc[SW-1:DROP];
        if (acc[SW-1])
            return 16'd0;
        else if (q > QW'(RGB_MAX))
            return RGB_MAX;
        else
            return q[15:0];
    endfunction

    function automatic logic [7:0] to_byte(logic signed [BW-1:0] acc);
        logic [TW-1:0] q;
        q = acc[BW-1:BSHIFT];
        if (acc[BW-1])
            return 8'd0;
        else if (q > TW'(255))
            return 8'd255;
        else
            return q[7:0];
    endfunction

    // Stage 1: offsets removed, forward products.
    logic signed [9:0]    y_d;
    logic signed [8:0]    u_d;
    logic signed [8:0]    v_d;
    logic signed [PW-1:0] m_ys, m_vr, m_ub, m_ug, m_vg;

    assign y_d  = $signed({2'b00, luma}) - 10'sd16;
    assign u_d  = $signed({1'b0, chroma_blue}) - 9'sd128;
    assign v_d  = $signed({1'b0, chroma_red}) - 9'sd128;
    assign m_ys = y_d * K_Y;
    assign m_vr = v_d * K_VR;
    assign m_ub = u_d * K_UB;
    assign m_ug = u_d * K_UG;
    assign m_vg = v_d * K_VG;

    logic signed [SW-1:0] s1_ys_reg, s1_vr_reg, s1_ub_reg, s1_ug_reg, s1_vg_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            s1_ys_reg <= $signed(m_ys[SW-1:0]);
            s1_vr_reg <= $signed(m_vr[SW-1:0]);
            s1_ub_reg <= $signed(m_ub[SW-1:0]);
            s1_ug_reg <= $signed(m_ug[SW-1:0]);
            s1_vg_reg <= $signed(m_vg[SW-1:0]);
        end
    end

    // Stage 2: RGB sums, floored to 8 fractional bits and clamped.
    logic signed [SW-1:0] acc_r, acc_g, acc_b;
    logic [15:0]          s2_r_reg, s2_g_reg, s2_b_reg;

    assign acc_r = s1_ys_reg + s1_vr_reg;
    assign acc_g = s1_ys_reg - s1_ug_reg - s1_vg_reg;
    assign acc_b = s1_ys_reg + s1_ub_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            s2_r_reg <= clamp_rgb(acc_r);
            s2_g_reg <= clamp_rgb(acc_g);
            s2_b_reg <= clamp_rgb(acc_b);
        end
    end

    // Stage 3: back-conversion products, all unsigned.
    logic [MW-1:0] s3_yr_reg, s3_yg_reg, s3_yb_reg;
    logic [MW-1:0] s3_ur_reg, s3_ug_reg, s3_ub_reg;
    logic [MW-1:0] s3_vr_reg, s3_vg_reg, s3_vb_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            s3_yr_reg <= MW'(K_RY) * MW'(s2_r_reg);
            s3_yg_reg <= MW'(K_GY) * MW'(s2_g_reg);
            s3_yb_reg <= MW'(K_BY) * MW'(s2_b_reg);
            s3_ur_reg <= MW'(K_RU) * MW'(s2_r_reg);
            s3_ug_reg <= MW'(K_GU) * MW'(s2_g_reg);
            s3_ub_reg <= MW'(K_BU) * MW'(s2_b_reg);
            s3_vr_reg <= MW'(K_RV) * MW'(s2_r_reg);
            s3_vg_reg <= MW'(K_GV) * MW'(s2_g_reg);
            s3_vb_reg <= MW'(K_BV) * MW'(s2_b_reg);
        end
    end

    // Stage 4: offsets added, floored to integers and limited to a byte.
    logic signed [BW-1:0] acc_y, acc_u, acc_v;
    yrr_pix_t             pix_reg;

    assign acc_y = OFF_Y + $signed({2'b00, s3_yr_reg}) + $signed({2'b00, s3_yg_reg})
                 + $signed({2'b00, s3_yb_reg});
    assign acc_u = OFF_UV - $signed({2'b00, s3_ur_reg}) - $signed({2'b00, s3_ug_reg})
                 + $signed({2'b00, s3_ub_reg});
    assign acc_v = OFF_UV + $signed({2'b00, s3_vr_reg}) - $signed({2'b00, s3_vg_reg})
                 - $signed({2'b00, s3_vb_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            pix_reg.y <= to_byte(acc_y);
            pix_reg.u <= to_byte(acc_u);
            pix_reg.v <= to_byte(acc_v);
        end
    end

    assign pix = pix_reg;

endmodule

// File: hdl/yrr_merge.sv
// ----------------------------------------------------------------------------
// yrr_merge: output stage that gathers the four lanes into one result
// Luma comes from every lane; chroma comes from the top-left lane only.
// ----------------------------------------------------------------------------
module yrr_merge (
    input  logic              clk,
    input  logic              en,
    input  yrr_pkg::yrr_pix_t pix [yrr_pkg::LANES],
    output yrr_pkg::yrr_res_t res
);
    import yrr_pkg::*;

    yrr_res_t res_reg;
    yrr_res_t res_next;

    always_comb
    begin
        res_next.new_luma_top_left     = pix[0].y;
        res_next.new_luma_top_right    = pix[1].y;
        res_next.new_luma_bottom_left  = pix[2].y;
        res_next.new_luma_bottom_right = pix[3].y;
        res_next.chroma_blue_out       = pix[0].u;
        res_next.chroma_red_out        = pix[0].v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: hdl/yrr_check.sv
// ----------------------------------------------------------------------------
// yrr_check: port-level checks of the YUV round-trip block
// Watches the two handshakes and the pipeline timing seen at the ports.
// ----------------------------------------------------------------------------
module yrr_check (
    input logic              clk,
    input logic              rst_n,
    input logic              blk_valid,
    input logic              blk_stall,
    input logic              res_valid,
    input logic              res_stall,
    input yrr_pkg::yrr_res_t res_data
);
    import yrr_pkg::*;

    // A result held back by the sink stays in place unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed or dropped");

    // The source is held off only when a result waits at the output and the sink stalls it.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        blk_stall |-> res_valid && res_stall)
        else $error("request stalled while the pipeline has room");

    // With the sink free, an accepted request passes every stage and shows as a valid result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && !blk_stall && !res_stall ##1 !res_stall ##1 !res_stall
        ##1 !res_stall ##1 !res_stall |=> res_valid)
        else $error("result missing five cycles after its request");

    // Reset leaves no result on the output.
    a_reset: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind yuv420_rgb_roundtrip_top yrr_check u_check (.*);
